// File: hdl/huffman_code_bit_packer_macros.svh
// Assertion macros shared by the packer modules.
`ifndef HUFFMAN_CODE_BIT_PACKER_MACROS_SVH
`define HUFFMAN_CODE_BIT_PACKER_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define HCBP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hcbp assertion failed");
// next-cycle implication
`define HCBP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hcbp assertion failed");
`else
`define HCBP_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define HCBP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// File: hdl/hcbp_pkg.sv
package hcbp_pkg;

  localparam int MAX_CODE_LEN = 32;
  localparam int SYMBOL_COUNT = 256;
  localparam int SYM_AW       = $clog2(SYMBOL_COUNT);
  localparam int BYTE_BITS    = 8;

  // request types
  localparam logic [1:0] REQ_LOAD   = 2'd0;
  localparam logic [1:0] REQ_ENCODE = 2'd1;
  localparam logic [1:0] REQ_FLUSH  = 2'd2;

  // one code table entry
  typedef struct packed {
    logic [5:0]  len;
    logic [31:0] val;
  } hcbp_entry_t;

  // request after table lookup
  typedef struct packed {
    logic [1:0]  req;
    logic [5:0]  len;
    logic [31:0] val;
  } hcbp_item_t;

  // bytes handed to the output buffer
  typedef struct packed {
    logic [31:0] word;        // bytes left aligned, first byte in the top
    logic [2:0]  cnt;         // number of bytes, 0..4
    logic        byte_valid;
    logic [2:0]  pad;
    logic        eos;
  } hcbp_res_t;

endpackage

// File: hdl/hcbp_table.sv
module hcbp_table (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  logic [1:0]         req,
  input  logic [7:0]         sym,
  input  logic [31:0]        val,
  input  logic [5:0]         len,
  input  logic               s1_adv,
  output hcbp_pkg::hcbp_item_t item,
  output logic               item_valid
);
  import hcbp_pkg::*;

  hcbp_entry_t             mem [SYMBOL_COUNT];
  logic [SYMBOL_COUNT-1:0] vld_r;
  hcbp_entry_t             rd_r;
  logic                    rd_vld_r;
  logic [1:0]              req_r;
  logic                    s1_valid_r;

  logic [SYM_AW-1:0] sym_idx;
  logic              sym_ok;
  logic [5:0]        len_sat;
  logic [32:0]       mask;
  hcbp_entry_t       wr_entry;
  logic              wr_en;

  // load path: saturate length, drop bits above it
  assign sym_idx  = sym[SYM_AW-1:0];
  assign sym_ok   = (int'(sym) < SYMBOL_COUNT);
  assign len_sat  = (int'(len) > MAX_CODE_LEN) ? 6'(MAX_CODE_LEN) : len;
  assign mask     = (33'd1 << len_sat) - 33'd1;
  assign wr_entry = '{len: len_sat, val: val & mask[31:0]};
  assign wr_en    = accept && (req == REQ_LOAD) && sym_ok;

  // table storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[sym_idx] <= wr_entry;
    end
    if (accept) begin
      rd_r <= mem[sym_idx];
    end
  end

  // entry valid bits, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[sym_idx] <= 1'b1;
    end
  end

  // lookup stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      rd_vld_r   <= 1'b0;
      req_r      <= REQ_LOAD;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
      rd_vld_r   <= sym_ok && vld_r[sym_idx];
      req_r      <= req;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  // unwritten or out-of-range entries read as empty
  assign item.req   = req_r;
  assign item.len   = rd_vld_r ? rd_r.len : 6'd0;
  assign item.val   = rd_vld_r ? rd_r.val : 32'd0;
  assign item_valid = s1_valid_r;

endmodule

// File: hdl/hcbp_pack.sv
`include "huffman_code_bit_packer_macros.svh"

module hcbp_pack (
  input  logic                 clk,
  input  logic                 rst_n,
  input  hcbp_pkg::hcbp_item_t item,
  input  logic                 item_valid,
  input  logic                 s2_free,
  output logic                 s1_adv,
  output hcbp_pkg::hcbp_res_t  res,
  output logic                 res_load
);
  import hcbp_pkg::*;

  logic [6:0] pend_bits_r, pend_bits_nxt;
  logic [2:0] pend_cnt_r, pend_cnt_nxt;

  logic [38:0] acc;
  logic [38:0] aligned;
  logic [5:0]  total;
  logic [2:0]  nb;
  logic [2:0]  rem;
  logic [5:0]  fill_sh;
  logic [6:0]  rem_mask;
  logic [2:0]  flush_pad;
  logic [7:0]  flush_byte;

  assign s1_adv = item_valid && s2_free;

  // append code bits behind the pending bits
  assign acc      = ({32'd0, pend_bits_r} << item.len) | {7'd0, item.val};
  assign total    = {3'd0, pend_cnt_r} + item.len;
  assign nb       = total[5:3];
  assign rem      = total[2:0];
  assign aligned  = acc >> rem;
  assign fill_sh  = {3'd4 - nb, 3'b000};
  assign rem_mask = (7'd1 << rem) - 7'd1;

  // flush: pad to a byte boundary (pad wraps to zero when empty)
  assign flush_pad  = 3'd0 - pend_cnt_r;
  assign flush_byte = {1'b0, pend_bits_r} << flush_pad;

  always_comb begin
    res           = '0;
    pend_bits_nxt = pend_bits_r;
    pend_cnt_nxt  = pend_cnt_r;
    case (item.req)
      REQ_ENCODE: begin
        res.word       = aligned[31:0] << fill_sh;
        res.cnt        = nb;
        res.byte_valid = 1'b1;
        pend_bits_nxt  = acc[6:0] & rem_mask;
        pend_cnt_nxt   = rem;
      end
      REQ_FLUSH: begin
        res.word       = {flush_byte, 24'd0};
        res.cnt        = 3'd1;
        res.byte_valid = (pend_cnt_r != 3'd0);
        res.pad        = flush_pad;
        res.eos        = 1'b1;
        pend_bits_nxt  = '0;
        pend_cnt_nxt   = '0;
      end
      default: begin
      end
    endcase
  end

  assign res_load = s1_adv && (res.cnt != 3'd0);

  // bit accumulator
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_bits_r <= '0;
      pend_cnt_r  <= '0;
    end else if (s1_adv) begin
      pend_bits_r <= pend_bits_nxt;
      pend_cnt_r  <= pend_cnt_nxt;
    end
  end

  `HCBP_ASSERT_NOW(a_pend_clean, clk, rst_n, (pend_cnt_r == 3'd0), (pend_bits_r == 7'd0))
  `HCBP_ASSERT_NOW(a_load_free, clk, rst_n, res_load, s2_free)
  `HCBP_ASSERT_NEXT(a_flush_empties, clk, rst_n, (s1_adv && item.req == REQ_FLUSH), (pend_cnt_r == 3'd0))

endmodule

// File: hdl/hcbp_out.sv
`include "huffman_code_bit_packer_macros.svh"

module hcbp_out (
  input  logic                clk,
  input  logic                rst_n,
  input  hcbp_pkg::hcbp_res_t res,
  input  logic                res_load,
  output logic                s2_free,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_byte,
  output logic                out_byte_valid,
  output logic [2:0]          out_pad_bits,
  output logic                out_end_of_stream,
  output logic                out_last
);
  import hcbp_pkg::*;

  logic [31:0] word_r;
  logic [2:0]  cnt_r;
  logic        bv_r;
  logic [2:0]  pad_r;
  logic        eos_r;
  logic        fire;

  assign fire    = out_valid && !out_stall;
  assign s2_free = (cnt_r == 3'd0) || (fire && cnt_r == 3'd1);

  // byte count of the buffered burst
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (res_load) begin
      cnt_r <= res.cnt;
    end else if (fire) begin
      cnt_r <= cnt_r - 3'd1;
    end
  end

  // payload: shift out one byte per output handshake
  always_ff @(posedge clk) begin
    if (res_load) begin
      word_r <= res.word;
      bv_r   <= res.byte_valid;
      pad_r  <= res.pad;
      eos_r  <= res.eos;
    end else if (fire) begin
      word_r <= {word_r[31-BYTE_BITS:0], {BYTE_BITS{1'b0}}};
    end
  end

  assign out_valid         = (cnt_r != 3'd0);
  assign out_byte          = word_r[31 -: BYTE_BITS];
  assign out_byte_valid    = bv_r;
  assign out_pad_bits      = pad_r;
  assign out_end_of_stream = eos_r;
  assign out_last          = (cnt_r == 3'd1);

  `HCBP_ASSERT_NOW(a_eos_last, clk, rst_n, (out_valid && out_end_of_stream), out_last)
  `HCBP_ASSERT_NEXT(a_burst_holds, clk, rst_n, (out_valid && !out_last), out_valid)
  `HCBP_ASSERT_NOW(a_burst_max, clk, rst_n, 1'b1, (cnt_r <= 3'd4))

endmodule

// File: hdl/huffman_code_bit_packer.sv
// Table-driven Huffman encoder and byte packer.
// Input channel (in_valid / in_stall): one request per accepted cycle.
//   LOAD writes a symbol's code into the 256-entry table, ENCODE appends the
//   code of in_symbol to the bit accumulator, FLUSH pads the partial byte.
// Output channel (out_valid / out_stall): zero to four packed bytes per
//   request, earliest bit in the MSB; out_last marks the final byte of a request.
//   A FLUSH always answers with one result carrying out_end_of_stream.
// Path: a request's table read is registered in the lookup stage when it is
//   accepted, and it is packed into the output buffer once that buffer is free.
// Throughput: one request per cycle while each yields at most one byte and
//   out_stall is low; an ENCODE completing up to four bytes holds the output
//   buffer until its last byte leaves, as the port moves one byte per cycle.
// Stall: when out_stall holds a burst, the lookup stage fills and
//   in_stall rises; nothing is dropped.
// Reset (rst_n low, synchronous): table valid bits, accumulator and all
//   stages clear at once; unwritten entries encode as empty (no bits).
module huffman_code_bit_packer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [7:0]  in_symbol,
  input  logic [31:0] in_code_value,
  input  logic [5:0]  in_code_length,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_byte_valid,
  output logic [2:0]  out_pad_bits,
  output logic        out_end_of_stream,
  output logic        out_last
);
  import hcbp_pkg::*;

  hcbp_item_t item;
  hcbp_res_t  res;
  logic       item_valid;
  logic       s1_adv;
  logic       s2_free;
  logic       res_load;
  logic       accept;

  // lookup stage may take a request when it is empty or moving on
  assign in_stall = item_valid && !s2_free;
  assign accept   = in_valid && !in_stall;

  hcbp_table u_table (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .req        (in_req_type),
    .sym        (in_symbol),
    .val        (in_code_value),
    .len        (in_code_length),
    .s1_adv     (s1_adv),
    .item       (item),
    .item_valid (item_valid)
  );

  hcbp_pack u_pack (
    .clk        (clk),
    .rst_n      (rst_n),
    .item       (item),
    .item_valid (item_valid),
    .s2_free    (s2_free),
    .s1_adv     (s1_adv),
    .res        (res),
    .res_load   (res_load)
  );

  hcbp_out u_out (
    .clk               (clk),
    .rst_n             (rst_n),
    .res               (res),
    .res_load          (res_load),
    .s2_free           (s2_free),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_byte          (out_byte),
    .out_byte_valid    (out_byte_valid),
    .out_pad_bits      (out_pad_bits),
    .out_end_of_stream (out_end_of_stream),
    .out_last          (out_last)
  );

endmodule

// File: sim/huffman_code_bit_packer_tb.sv
`timescale 1ns / 1ps

module huffman_code_bit_packer_tb;
  import hcbp_pkg::*;

  // req_type code the block ignores
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int IDLE_PCT       = 21;
  localparam int RANDOM_REQS    = 140;

  typedef struct packed {
    logic [1:0]  req;
    logic [7:0]  sym;
    logic [31:0] val;
    logic [5:0]  len;
    logic        drain;   // hold this request until every byte is out
  } request_t;

  typedef struct packed {
    logic [7:0] data;
    logic       byte_valid;
    logic [2:0] pad;
    logic       eos;
    logic       last;
  } packed_byte_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_req_type;
  logic [7:0]  in_symbol;
  logic [31:0] in_code_value;
  logic [5:0]  in_code_length;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_byte;
  logic        out_byte_valid;
  logic [2:0]  out_pad_bits;
  logic        out_end_of_stream;
  logic        out_last;

  huffman_code_bit_packer u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_symbol        (in_symbol),
    .in_code_value    (in_code_value),
    .in_code_length   (in_code_length),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte         (out_byte),
    .out_byte_valid   (out_byte_valid),
    .out_pad_bits     (out_pad_bits),
    .out_end_of_stream(out_end_of_stream),
    .out_last         (out_last)
  );

  // shadow code table and bit accumulator
  logic [5:0]  code_len [0:SYMBOL_COUNT-1];
  logic [31:0] code_val [0:SYMBOL_COUNT-1];
  logic [6:0]  acc_bits;
  logic [2:0]  acc_cnt;

  request_t     pending_reqs[$];
  packed_byte_t expected_bytes[$];

  int  errors;
  int  reqs_taken;
  int  stale_cycles;
  int  n_loads, n_encodes, n_flushes, n_ignored, n_bytes, n_eos;
  logic in_taken;
  logic calm;

  // no idling on either side through a stretch in the middle of the run
  assign calm = (reqs_taken >= 60) && (reqs_taken < 110);

  always #4 clk = ~clk;

  // work out the bytes one accepted request produces
  task automatic predict_request(input request_t r);
    logic [5:0]   ln;
    logic [63:0]  acc;
    int           total;
    int           nbytes;
    packed_byte_t b;
    case (r.req)
      REQ_LOAD: begin
        n_loads++;
        ln = r.len;
        if (ln > MAX_CODE_LEN) ln = 6'(MAX_CODE_LEN);
        if (ln > 6'd32) ln = 6'd32;
        code_len[r.sym] = ln;
        code_val[r.sym] = 32'({32'd0, r.val} & ((64'd1 << ln) - 64'd1));
      end
      REQ_ENCODE: begin
        n_encodes++;
        ln = code_len[r.sym];
        if (ln != 6'd0) begin
          acc    = ({57'd0, acc_bits} << ln) | {32'd0, code_val[r.sym]};
          total  = int'(acc_cnt) + int'(ln);
          nbytes = total / BYTE_BITS;
          for (int k = 0; k < nbytes; k++) begin
            b.data       = 8'(acc >> (total - BYTE_BITS * (k + 1)));
            b.byte_valid = 1'b1;
            b.pad        = 3'd0;
            b.eos        = 1'b0;
            b.last       = (k == nbytes - 1);
            expected_bytes = {expected_bytes, b};
          end
          total    = total % BYTE_BITS;
          acc_bits = 7'(acc & ((64'd1 << total) - 64'd1));
          acc_cnt  = 3'(total);
        end
      end
      REQ_FLUSH: begin
        n_flushes++;
        b.eos  = 1'b1;
        b.last = 1'b1;
        if (acc_cnt == 3'd0) begin
          b.data       = 8'd0;
          b.byte_valid = 1'b0;
          b.pad        = 3'd0;
        end else begin
          b.pad        = 3'(BYTE_BITS - int'(acc_cnt));
          b.data       = 8'({1'b0, acc_bits}) << b.pad;
          b.byte_valid = 1'b1;
        end
        expected_bytes = {expected_bytes, b};
        acc_bits = 7'd0;
        acc_cnt  = 3'd0;
      end
      default: n_ignored++;
    endcase
  endtask

  task automatic queue_request(input logic [1:0] req, input logic [7:0] sym,
                               input logic [31:0] val, input logic [5:0] len,
                               input logic drain);
    request_t r;
    r.req   = req;
    r.sym   = sym;
    r.val   = val;
    r.len   = len;
    r.drain = drain;
    pending_reqs = {pending_reqs, r};
  endtask

  // driver: new request and receiver stall at the falling edge
  always @(negedge clk) begin
    request_t nxt;
    logic     present;
    if (rst_n) begin
      out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
      if (!in_valid || in_taken) begin
        present = 1'b0;
        if (pending_reqs.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT) &&
            !(pending_reqs[0].drain && expected_bytes.size() != 0)) begin
          nxt            = pending_reqs.pop_front();
          present        = 1'b1;
          in_req_type    <= nxt.req;
          in_symbol      <= nxt.sym;
          in_code_value  <= nxt.val;
          in_code_length <= nxt.len;
        end
        in_valid <= present;
      end
    end
  end

  // monitor: predict on accepted requests, check accepted result bytes
  always @(posedge clk) begin
    request_t     r;
    packed_byte_t exp_b;
    logic         out_taken;
    in_taken  = 1'b0;
    out_taken = 1'b0;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        in_taken = 1'b1;
        r.req    = in_req_type;
        r.sym    = in_symbol;
        r.val    = in_code_value;
        r.len    = in_code_length;
        r.drain  = 1'b0;
        predict_request(r);
        reqs_taken++;
      end
      if (out_valid && !out_stall) begin
        out_taken = 1'b1;
        if (expected_bytes.size() == 0) begin
          $error("unexpected result: out_byte %0h byte_valid %0b eos %0b",
                 out_byte, out_byte_valid, out_end_of_stream);
          errors++;
        end else begin
          exp_b = expected_bytes.pop_front();
          n_bytes++;
          if (exp_b.eos) n_eos++;
          if (out_byte !== exp_b.data) begin
            $error("out_byte: expected %0h, got %0h", exp_b.data, out_byte);
            errors++;
          end
          if (out_byte_valid !== exp_b.byte_valid) begin
            $error("out_byte_valid: expected %0b, got %0b", exp_b.byte_valid,
                   out_byte_valid);
            errors++;
          end
          if (out_pad_bits !== exp_b.pad) begin
            $error("out_pad_bits: expected %0d, got %0d", exp_b.pad, out_pad_bits);
            errors++;
          end
          if (out_end_of_stream !== exp_b.eos) begin
            $error("out_end_of_stream: expected %0b, got %0b", exp_b.eos,
                   out_end_of_stream);
            errors++;
          end
          if (out_last !== exp_b.last) begin
            $error("out_last: expected %0b, got %0b", exp_b.last, out_last);
            errors++;
          end
        end
      end
      if (in_taken || out_taken) stale_cycles = 0;
      else stale_cycles++;
    end
  end

  // watchdog on handshake activity
  always @(negedge clk) begin
    if (stale_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int         loaded_syms[$];
    int         pick;
    int         lsel;
    logic [7:0] sym;
    logic [5:0] len;

    clk            = 1'b0;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_req_type    = REQ_LOAD;
    in_symbol      = 8'd0;
    in_code_value  = 32'd0;
    in_code_length = 6'd0;
    out_stall      = 1'b0;
    in_taken       = 1'b0;
    errors         = 0;
    reqs_taken     = 0;
    stale_cycles   = 0;
    n_loads = 0; n_encodes = 0; n_flushes = 0; n_ignored = 0;
    n_bytes = 0; n_eos = 0;
    acc_bits = 7'd0;
    acc_cnt  = 3'd0;
    for (int i = 0; i < SYMBOL_COUNT; i++) begin
      code_len[i] = 6'd0;
      code_val[i] = 32'd0;
    end

    // directed: empty flush, cleared entries, saturation, byte boundaries, ignored request
    queue_request(REQ_FLUSH,  8'd0,   32'd0,          6'd0,  1'b0);
    queue_request(REQ_ENCODE, 8'd9,   32'd0,          6'd0,  1'b0);
    queue_request(REQ_LOAD,   8'd0,   32'hDEAD_BEEF,  6'd0,  1'b0);
    queue_request(REQ_LOAD,   8'd255, 32'hFFFF_FFFF,  6'd32, 1'b0);
    queue_request(REQ_LOAD,   8'd1,   32'h0000_0001,  6'd1,  1'b0);
    queue_request(REQ_LOAD,   8'd2,   32'hA5A5_A5A5,  6'd63, 1'b0);
    queue_request(REQ_LOAD,   8'd3,   32'hFFFF_FF55,  6'd7,  1'b0);
    queue_request(REQ_LOAD,   8'd4,   32'h0000_0000,  6'd8,  1'b0);
    queue_request(REQ_ENCODE, 8'd255, 32'd0,          6'd0,  1'b0);
    queue_request(REQ_ENCODE, 8'd1,   32'd0,          6'd0,  1'b0);
    queue_request(REQ_ENCODE, 8'd2,   32'd0,          6'd0,  1'b0);
    queue_request(REQ_ENCODE, 8'd3,   32'd0,          6'd0,  1'b0);
    queue_request(REQ_FLUSH,  8'd0,   32'd0,          6'd0,  1'b0);
    queue_request(REQ_ENCODE, 8'd1,   32'd0,          6'd0,  1'b0);
    queue_request(REQ_FLUSH,  8'd0,   32'd0,          6'd0,  1'b0);
    queue_request(REQ_ENCODE, 8'd3,   32'd0,          6'd0,  1'b0);
    queue_request(REQ_ENCODE, 8'd0,   32'd0,          6'd0,  1'b0);
    queue_request(REQ_UNUSED, 8'd255, 32'hFFFF_FFFF,  6'd63, 1'b0);
    queue_request(REQ_FLUSH,  8'd0,   32'd0,          6'd0,  1'b0);
    queue_request(REQ_ENCODE, 8'd4,   32'd0,          6'd0,  1'b0);
    queue_request(REQ_ENCODE, 8'd255, 32'd0,          6'd0,  1'b0);
    queue_request(REQ_FLUSH,  8'd0,   32'd0,          6'd0,  1'b0);
    loaded_syms = '{255, 1, 2, 3, 4};

    // random: table loads up front, then mostly encodes of loaded symbols
    for (int i = 0; i < RANDOM_REQS; i++) begin
      pick = (i < 12) ? 0 : int'($urandom_range(99));
      if (pick < 20) begin
        sym  = 8'($urandom_range(255));
        lsel = int'($urandom_range(9));
        if (lsel == 0) len = 6'd0;
        else if (lsel == 1) len = 6'($urandom_range(63, 33));
        else if (lsel < 6) len = 6'($urandom_range(12, 1));
        else len = 6'($urandom_range(32, 1));
        if (len != 6'd0) loaded_syms = {loaded_syms, int'(sym)};
        queue_request(REQ_LOAD, sym, $urandom, len, i == 90);
      end else if (pick < 82) begin
        if ($urandom_range(9) != 0)
          sym = 8'(loaded_syms[$urandom_range(loaded_syms.size() - 1)]);
        else
          sym = 8'($urandom_range(255));
        queue_request(REQ_ENCODE, sym, $urandom, 6'($urandom_range(63)), i == 90);
      end else if (pick < 94) begin
        queue_request(REQ_FLUSH, 8'($urandom_range(255)), $urandom,
                      6'($urandom_range(63)), i == 90);
      end else begin
        queue_request(REQ_UNUSED, 8'($urandom_range(255)), $urandom,
                      6'($urandom_range(63)), i == 90);
      end
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    wait (pending_reqs.size() == 0 && !in_valid);
    wait (expected_bytes.size() == 0);
    repeat (10) @(posedge clk);

    $display("Requests: %0d loads, %0d encodes, %0d flushes, %0d ignored",
             n_loads, n_encodes, n_flushes, n_ignored);
    $display("Checked %0d result bytes, %0d of them ending a stream", n_bytes, n_eos);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
